FILE: sv/gpu_scalar_alu_with_condition_flag_unit_defines.svh
// ---------------------------------------------------------------------------
// Scalar ALU assertion macros
// Shared property wrappers for the scalar ALU block, clocked on clk and
// disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef GPU_SCALAR_ALU_WITH_CONDITION_FLAG_UNIT_DEFINES_SVH
`define GPU_SCALAR_ALU_WITH_CONDITION_FLAG_UNIT_DEFINES_SVH

// Same-cycle implication
`define GSALU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define GSALU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/gsalu_pkg.sv
// ---------------------------------------------------------------------------
// Scalar ALU package
// Opcode encoding, widths and the result bundle shared by the ALU modules.
// ---------------------------------------------------------------------------
package gsalu_pkg;

  localparam int OP_W   = 6;
  localparam int DATA_W = 64;
  localparam int HALF_W = 32;

  localparam logic [HALF_W-1:0] MASK32 = 32'hFFFF_FFFF;

  typedef enum logic [OP_W-1:0] {
    OP_MOV32       = 6'd0,
    OP_MOV64       = 6'd1,
    OP_MOVK        = 6'd2,
    OP_FF1         = 6'd3,
    OP_SEXT16      = 6'd4,
    OP_ABS         = 6'd5,
    OP_CMOV        = 6'd6,
    OP_AND32       = 6'd7,
    OP_AND64       = 6'd8,
    OP_ANDN2_32    = 6'd9,
    OP_LSHL32      = 6'd10,
    OP_LSHL64      = 6'd11,
    OP_ASHR32      = 6'd12,
    OP_LSHR32      = 6'd13,
    OP_ANDN2_64    = 6'd14,
    OP_OR32        = 6'd15,
    OP_ORN2_64     = 6'd16,
    OP_XOR32       = 6'd17,
    OP_XOR64       = 6'd18,
    OP_OR64        = 6'd19,
    OP_CSELECT     = 6'd20,
    OP_BFE_U32     = 6'd21,
    OP_BFM         = 6'd22,
    OP_LSHL2_ADD   = 6'd23,
    OP_MUL_I32     = 6'd24,
    OP_MUL_HI_U32  = 6'd25,
    OP_MUL_HI_I32  = 6'd26,
    OP_ADD_I32     = 6'd27,
    OP_SUB_I32     = 6'd28,
    OP_ADD_U32     = 6'd29,
    OP_SUB_U32     = 6'd30,
    OP_ADDC        = 6'd31,
    OP_SUBB        = 6'd32,
    OP_CMP_EQ_U32  = 6'd33,
    OP_CMP_EQ_I32  = 6'd34,
    OP_CMP_LT_I32  = 6'd35,
    OP_CMP_LT_U32  = 6'd36,
    OP_CMP_LE_I32  = 6'd37,
    OP_CMP_LE_U32  = 6'd38,
    OP_CMP_LG_U32  = 6'd39,
    OP_CMP_GE_I32  = 6'd40,
    OP_CMP_EQ_U64  = 6'd41,
    OP_CMP_GT_I32  = 6'd42,
    OP_CMP_GT_U32  = 6'd43,
    OP_CMP_GE_U32  = 6'd44,
    OP_ADDK        = 6'd45,
    OP_CMPK_EQ_I32 = 6'd46,
    OP_CMPK_EQ_U32 = 6'd47,
    OP_CMPK_GT_U32 = 6'd48,
    OP_CMPK_LG_U32 = 6'd49
  } op_t;

  typedef struct packed {
    logic [DATA_W-1:0] result;
    logic              writes_dest;
    logic              flag;
  } res_t;

endpackage

FILE: sv/gsalu_exec.sv
// ---------------------------------------------------------------------------
// Scalar ALU execute logic
// Single-pass combinational datapath: one shared 33-bit adder, one 33x33
// multiplier, shifters, logic ops and compares, plus the flag update.
// ---------------------------------------------------------------------------
module gsalu_exec (
  input  logic [gsalu_pkg::OP_W-1:0]   op,
  input  logic [gsalu_pkg::DATA_W-1:0] operand_a,
  input  logic [gsalu_pkg::DATA_W-1:0] operand_b,
  input  logic                         flag_in,
  output gsalu_pkg::res_t              res
);

  logic [31:0] a32;
  logic [31:0] b32;
  logic [4:0]  sh5;
  logic [5:0]  sh6;
  logic [31:0] imm_s;
  logic [31:0] imm_u;

  logic [4:0]  ff1_cnt;

  logic        add_sub;
  logic        add_cin;
  logic [31:0] add_y;
  logic [32:0] add_sum;
  logic        ovf_add;
  logic        ovf_sub;

  logic               mul_sgn;
  logic signed [32:0] mul_x;
  logic signed [32:0] mul_y;
  logic signed [65:0] mul_p;

  logic [34:0] sa2_sum;

  logic [6:0]  bfe_w;
  logic [31:0] bfe_v;
  logic [31:0] bfe_r;
  logic [31:0] bfm_r;

  logic eq32;
  logic lt_s;
  logic lt_u;

  logic [63:0] r;
  logic        wr;
  logic        f;
  logic        cmp_en;
  logic        cmp_v;

  assign a32   = operand_a[31:0];
  assign b32   = operand_b[31:0];
  assign sh5   = operand_b[4:0];
  assign sh6   = operand_b[5:0];
  assign imm_s = {{16{operand_b[15]}}, operand_b[15:0]};
  assign imm_u = {16'd0, operand_b[15:0]};

  // lowest set bit
  always_comb begin
    ff1_cnt = '0;
    for (int i = 31; i >= 0; i--) begin
      if (a32[i]) begin
        ff1_cnt = 5'(i);
      end
    end
  end

  // Shared add/sub: subtraction as a + ~y + cin, bit 32 is carry or borrow
  always_comb begin
    add_sub = (op == gsalu_pkg::OP_SUB_I32) || (op == gsalu_pkg::OP_SUB_U32) ||
              (op == gsalu_pkg::OP_SUBB);
    add_y   = (op == gsalu_pkg::OP_ADDK) ? imm_s : b32;
    unique case (op) inside
      gsalu_pkg::OP_ADDC:                        add_cin = flag_in;
      gsalu_pkg::OP_SUBB:                        add_cin = ~flag_in;
      gsalu_pkg::OP_SUB_I32, gsalu_pkg::OP_SUB_U32: add_cin = 1'b1;
      default:                                   add_cin = 1'b0;
    endcase
    add_sum = {1'b0, a32} + (add_sub ? {1'b1, ~add_y} : {1'b0, add_y}) + 33'(add_cin);
    ovf_add = (a32[31] == add_y[31]) && (a32[31] != add_sum[31]);
    ovf_sub = (a32[31] != add_y[31]) && (a32[31] != add_sum[31]);
  end

  // One signed 33x33 multiplier covers both unsigned and signed forms
  assign mul_sgn = (op == gsalu_pkg::OP_MUL_HI_I32);
  assign mul_x   = $signed({mul_sgn & a32[31], a32});
  assign mul_y   = $signed({mul_sgn & b32[31], b32});
  assign mul_p   = mul_x * mul_y;

  assign sa2_sum = {1'b0, a32, 2'b00} + {3'b000, b32};

  always_comb begin
    bfe_w = operand_b[22:16];
    bfe_v = a32 >> operand_b[4:0];
    if (bfe_w == 7'd0) begin
      bfe_r = '0;
    end else if (bfe_w >= 7'd32) begin
      bfe_r = bfe_v;
    end else begin
      bfe_r = bfe_v & ~(gsalu_pkg::MASK32 << bfe_w[4:0]);
    end
    bfm_r = (~(gsalu_pkg::MASK32 << operand_a[4:0])) << sh5;
  end

  assign eq32 = (a32 == b32);
  assign lt_s = ($signed(a32) < $signed(b32));
  assign lt_u = (a32 < b32);

  always_comb begin
    r      = '0;
    wr     = 1'b1;
    f      = flag_in;
    cmp_en = 1'b0;
    cmp_v  = 1'b0;
    unique case (op) inside
      gsalu_pkg::OP_MOV32:     r = {32'd0, a32};
      gsalu_pkg::OP_MOV64:     r = operand_a;
      gsalu_pkg::OP_MOVK:      r = {32'd0, imm_s};
      gsalu_pkg::OP_FF1:       r = (a32 == '0) ? {32'd0, gsalu_pkg::MASK32}
                                               : {59'd0, ff1_cnt};
      gsalu_pkg::OP_SEXT16:    r = {32'd0, {16{a32[15]}}, a32[15:0]};
      gsalu_pkg::OP_ABS: begin
        r = {32'd0, a32[31] ? (32'd0 - a32) : a32};
        f = (r != '0);
      end
      gsalu_pkg::OP_CMOV: begin
        if (flag_in) begin
          r = {32'd0, a32};
        end else begin
          wr = 1'b0;
        end
      end
      gsalu_pkg::OP_AND32:     r = {32'd0, a32 & b32};
      gsalu_pkg::OP_AND64:     r = operand_a & operand_b;
      gsalu_pkg::OP_ANDN2_32:  r = {32'd0, a32 & ~b32};
      gsalu_pkg::OP_LSHL32:    r = {32'd0, a32 << sh5};
      gsalu_pkg::OP_LSHL64:    r = operand_a << sh6;
      gsalu_pkg::OP_ASHR32:    r = {32'd0, $unsigned($signed(a32) >>> sh5)};
      gsalu_pkg::OP_LSHR32:    r = {32'd0, a32 >> sh5};
      gsalu_pkg::OP_ANDN2_64:  r = operand_a & ~operand_b;
      gsalu_pkg::OP_OR32:      r = {32'd0, a32 | b32};
      gsalu_pkg::OP_ORN2_64:   r = operand_a | ~operand_b;
      gsalu_pkg::OP_XOR32:     r = {32'd0, a32 ^ b32};
      gsalu_pkg::OP_XOR64:     r = operand_a ^ operand_b;
      gsalu_pkg::OP_OR64:      r = operand_a | operand_b;
      gsalu_pkg::OP_CSELECT:   r = {32'd0, flag_in ? a32 : b32};
      gsalu_pkg::OP_BFE_U32: begin
        r = {32'd0, bfe_r};
        f = (bfe_r != '0);
      end
      gsalu_pkg::OP_BFM:       r = {32'd0, bfm_r};
      gsalu_pkg::OP_LSHL2_ADD: begin
        r = {32'd0, sa2_sum[31:0]};
        f = |sa2_sum[34:32];
      end
      gsalu_pkg::OP_MUL_I32:    r = {32'd0, mul_p[31:0]};
      gsalu_pkg::OP_MUL_HI_U32,
      gsalu_pkg::OP_MUL_HI_I32: r = {32'd0, mul_p[63:32]};
      gsalu_pkg::OP_ADD_I32, gsalu_pkg::OP_ADDK: begin
        r = {32'd0, add_sum[31:0]};
        f = ovf_add;
      end
      gsalu_pkg::OP_SUB_I32: begin
        r = {32'd0, add_sum[31:0]};
        f = ovf_sub;
      end
      gsalu_pkg::OP_ADD_U32, gsalu_pkg::OP_SUB_U32,
      gsalu_pkg::OP_ADDC, gsalu_pkg::OP_SUBB: begin
        r = {32'd0, add_sum[31:0]};
        f = add_sum[32];
      end
      gsalu_pkg::OP_CMP_EQ_U32,
      gsalu_pkg::OP_CMP_EQ_I32: begin cmp_en = 1'b1; cmp_v = eq32;            end
      gsalu_pkg::OP_CMP_LT_I32: begin cmp_en = 1'b1; cmp_v = lt_s;            end
      gsalu_pkg::OP_CMP_LT_U32: begin cmp_en = 1'b1; cmp_v = lt_u;            end
      gsalu_pkg::OP_CMP_LE_I32: begin cmp_en = 1'b1; cmp_v = lt_s | eq32;     end
      gsalu_pkg::OP_CMP_LE_U32: begin cmp_en = 1'b1; cmp_v = lt_u | eq32;     end
      gsalu_pkg::OP_CMP_LG_U32: begin cmp_en = 1'b1; cmp_v = ~eq32;           end
      gsalu_pkg::OP_CMP_GE_I32: begin cmp_en = 1'b1; cmp_v = ~lt_s;           end
      gsalu_pkg::OP_CMP_EQ_U64: begin
        cmp_en = 1'b1;
        cmp_v  = (operand_a == operand_b);
      end
      gsalu_pkg::OP_CMP_GT_I32: begin cmp_en = 1'b1; cmp_v = ~(lt_s | eq32);  end
      gsalu_pkg::OP_CMP_GT_U32: begin cmp_en = 1'b1; cmp_v = ~(lt_u | eq32);  end
      gsalu_pkg::OP_CMP_GE_U32: begin cmp_en = 1'b1; cmp_v = ~lt_u;           end
      gsalu_pkg::OP_CMPK_EQ_I32: begin cmp_en = 1'b1; cmp_v = (a32 == imm_s); end
      gsalu_pkg::OP_CMPK_EQ_U32: begin cmp_en = 1'b1; cmp_v = (a32 == imm_u); end
      gsalu_pkg::OP_CMPK_GT_U32: begin cmp_en = 1'b1; cmp_v = (a32 > imm_u);  end
      gsalu_pkg::OP_CMPK_LG_U32: begin cmp_en = 1'b1; cmp_v = (a32 != imm_u); end
      default:                   wr = 1'b0;
    endcase

    // logic and shift ops set the flag from a non-zero result
    if ((op >= gsalu_pkg::OP_AND32) && (op <= gsalu_pkg::OP_OR64)) begin
      f = (r != '0);
    end

    if (cmp_en) begin
      r  = '0;
      wr = 1'b0;
      f  = cmp_v;
    end
  end

  assign res.result      = r;
  assign res.writes_dest = wr;
  assign res.flag        = f;

endmodule

FILE: sv/gpu_scalar_alu_with_condition_flag_unit.sv
// ---------------------------------------------------------------------------
// Scalar ALU with condition flag - top level
// Registers: input register, then result register; an item waits in the input register while the output stalls.
// Throughput: one item per cycle unless the output stalls; flag carried between items in one register.
// Reset: synchronous active-low rst_n clears both valid bits and the flag.
// ---------------------------------------------------------------------------
`include "gpu_scalar_alu_with_condition_flag_unit_defines.svh"

module gpu_scalar_alu_with_condition_flag_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [gsalu_pkg::OP_W-1:0]   in_op,
  input  logic [gsalu_pkg::DATA_W-1:0] in_operand_a,
  input  logic [gsalu_pkg::DATA_W-1:0] in_operand_b,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [gsalu_pkg::DATA_W-1:0] out_result,
  output logic                         out_writes_dest,
  output logic                         out_flag_out
);

  logic                         s1_valid_r;
  logic                         s1_valid_nxt;
  logic [gsalu_pkg::OP_W-1:0]   s1_op_r;
  logic [gsalu_pkg::DATA_W-1:0] s1_a_r;
  logic [gsalu_pkg::DATA_W-1:0] s1_b_r;

  logic                         out_valid_r;
  logic                         out_valid_nxt;
  gsalu_pkg::res_t              out_res_r;

  logic                         flag_r;
  gsalu_pkg::res_t              exec_res;

  logic out_free;
  logic adv;
  logic in_xfer;

  logic out_nowr;
  logic s1_is_cmp;
  logic s1_cmov_clr;

  assign out_free = ~out_valid_r | ~out_stall;
  assign adv      = s1_valid_r & out_free;
  assign in_stall = s1_valid_r & ~out_free;
  assign in_xfer  = in_valid & ~in_stall;

  assign s1_valid_nxt  = in_xfer | (s1_valid_r & ~adv);
  assign out_valid_nxt = adv | (out_valid_r & out_stall);

  gsalu_exec u_exec (
    .op        (s1_op_r),
    .operand_a (s1_a_r),
    .operand_b (s1_b_r),
    .flag_in   (flag_r),
    .res       (exec_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flag_r      <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      // flag advances with the item leaving the input register
      if (adv) begin
        flag_r <= exec_res.flag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op_r <= in_op;
      s1_a_r  <= in_operand_a;
      s1_b_r  <= in_operand_b;
    end
    if (adv) begin
      out_res_r <= exec_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result      = out_res_r.result;
  assign out_writes_dest = out_res_r.writes_dest;
  assign out_flag_out    = out_res_r.flag;

  assign out_nowr    = out_valid_r & ~out_res_r.writes_dest;
  assign s1_is_cmp   = ((s1_op_r >= gsalu_pkg::OP_CMP_EQ_U32) &&
                        (s1_op_r <= gsalu_pkg::OP_CMP_GE_U32)) ||
                       ((s1_op_r >= gsalu_pkg::OP_CMPK_EQ_I32) &&
                        (s1_op_r <= gsalu_pkg::OP_CMPK_LG_U32));
  assign s1_cmov_clr = adv & (s1_op_r == gsalu_pkg::OP_CMOV) & ~flag_r;

  `GSALU_ASSERT_IMP(a_nowr_zero, out_nowr, out_res_r.result == '0, "result set without write")
  `GSALU_ASSERT_NXT(a_cmp_nowr, adv && s1_is_cmp, !out_writes_dest, "compare wrote dest")
  `GSALU_ASSERT_NXT(a_flag_hold, !adv, $stable(flag_r), "flag moved without transfer")
  `GSALU_ASSERT_NXT(a_cmov_clear, s1_cmov_clr, !out_writes_dest && !flag_r, "cmov wrote dest")

endmodule
